// File: sv/pmv_pkg.sv
// Shared types, constants and the control program for the motor voltage controller.
// Depends on nothing; every other file of the block imports it.
package pmv_pkg;

    // Number formats.
    localparam int FRAC_BITS      = 16;
    localparam int INTEGRAL_WIDTH = 48;
    localparam int VOLT_LIMIT     = 98304;
    localparam int SINE_FRAC      = 15;

    localparam int WORD_W    = 32;
    localparam int SINE_W    = 16;
    localparam int DRIVE_W   = 18;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W      = 4;

    // Error is one bit wider than a speed, the error difference two bits wider.
    localparam int ERR_W  = WORD_W + 1;
    localparam int DIFF_W = WORD_W + 2;
    localparam int OPA_W  = DIFF_W;
    localparam int PROD_W = OPA_W + WORD_W;
    // The accumulator holds any sum of a few shifted products and the integral exactly.
    localparam int ACC_W  = PROD_W + 2;

    // Mode register bits.
    localparam int MODE_PD_BIT  = 0;
    localparam int MODE_NEG_BIT = 1;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_W'(2);

    // Saturation and clamp limits at accumulator width.
    localparam logic signed [ACC_W-1:0] LOOP_MAX =
        {{(ACC_W - WORD_W + 1){1'b0}}, {(WORD_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] LOOP_MIN = ~LOOP_MAX;
    localparam logic signed [ACC_W-1:0] INTEG_MAX =
        {{(ACC_W - INTEGRAL_WIDTH + 1){1'b0}}, {(INTEGRAL_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] INTEG_MIN = ~INTEG_MAX;
    localparam logic signed [ACC_W-1:0] VOLT_HI = ACC_W'(VOLT_LIMIT);
    localparam logic signed [ACC_W-1:0] VOLT_LO_NEG = -VOLT_HI;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN,
        CFG_INTEG_GAIN_DT,
        CFG_DERIV_GAIN_PER_DT,
        CFG_MODE,
        CFG_SPEED_COEF,
        CFG_FRICTION_COEF,
        CFG_ACCEL_COEF,
        CFG_GRAVITY_COEF
    } cfg_reg_e;

    typedef struct packed {
        logic [WORD_W-1:0] prop_gain;
        logic [WORD_W-1:0] integ_gain_dt;
        logic [WORD_W-1:0] deriv_gain_per_dt;
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] speed_coef;
        logic [WORD_W-1:0] friction_coef;
        logic [WORD_W-1:0] accel_coef;
        logic [WORD_W-1:0] gravity_coef;
    } cfg_t;

    // Control word fields.
    typedef enum logic [2:0] {
        OPA_ERR, OPA_DIFF, OPA_NEG_MEAS, OPA_MEAS, OPA_LOOP, OPA_SINE
    } opa_sel_e;

    typedef enum logic [2:0] {
        OPB_KI, OPB_KP, OPB_KD, OPB_SPEED, OPB_ACCEL, OPB_GRAV
    } opb_sel_e;

    typedef enum logic {
        SHIFT_Q, SHIFT_SINE
    } shift_sel_e;

    typedef enum logic [1:0] {
        BASE_ZERO, BASE_ACC, BASE_INTEG
    } acc_base_e;

    typedef enum logic [1:0] {
        ADD_NONE, ADD_PROD, ADD_INTEG, ADD_FRIC
    } acc_add_e;

    typedef enum logic [1:0] {
        JMP_NONE, JMP_ALWAYS, JMP_IF_PD
    } jump_cond_e;

    // Program steps.
    typedef enum logic [PC_W-1:0] {
        PC_ISSUE,
        PC_PID_KP,
        PC_PID_KD,
        PC_PID_ADD_KD,
        PC_ADD_INTEG,
        PC_LOOP,
        PC_FRIC,
        PC_ACCEL,
        PC_GRAV,
        PC_DONE,
        PC_PD_KP,
        PC_PD_LOAD
    } step_e;

    typedef struct packed {
        logic       mul_en;
        opa_sel_e   opa;
        opb_sel_e   opb;
        shift_sel_e shift;
        logic       acc_en;
        acc_base_e  base;
        acc_add_e   add;
        logic       wr_integ;
        logic       wr_loop;
        logic       done;
        jump_cond_e jump;
        step_e      target;
    } ucode_t;

    typedef struct packed {
        logic   accept;
        logic   step_en;
        ucode_t word;
    } seq_ctrl_t;

    // Control program. A product issued in one step is in the product
    // register in the next step.
    function automatic ucode_t ucode_rom(input step_e pc);
        ucode_t w;
        w = '0;
        unique case (pc)
            PC_ISSUE: begin
                // Integral increment; PD mode branches off here.
                w.mul_en = 1'b1; w.opa = OPA_ERR; w.opb = OPB_KI;
                w.jump = JMP_IF_PD; w.target = PC_PD_KP;
            end
            PC_PID_KP: begin
                w.acc_en = 1'b1; w.base = BASE_INTEG; w.add = ADD_PROD;
                w.mul_en = 1'b1; w.opa = OPA_ERR; w.opb = OPB_KP;
            end
            PC_PID_KD: begin
                w.wr_integ = 1'b1;
                w.acc_en = 1'b1; w.base = BASE_ZERO; w.add = ADD_PROD;
                w.mul_en = 1'b1; w.opa = OPA_DIFF; w.opb = OPB_KD;
            end
            PC_PID_ADD_KD: begin
                w.acc_en = 1'b1; w.base = BASE_ACC; w.add = ADD_PROD;
            end
            PC_ADD_INTEG: begin
                w.acc_en = 1'b1; w.base = BASE_ACC; w.add = ADD_INTEG;
                w.mul_en = 1'b1; w.opa = OPA_MEAS; w.opb = OPB_SPEED;
            end
            PC_LOOP: begin
                w.wr_loop = 1'b1;
                w.acc_en = 1'b1; w.base = BASE_ZERO; w.add = ADD_PROD;
            end
            PC_FRIC: begin
                w.acc_en = 1'b1; w.base = BASE_ACC; w.add = ADD_FRIC;
                w.mul_en = 1'b1; w.opa = OPA_LOOP; w.opb = OPB_ACCEL;
            end
            PC_ACCEL: begin
                w.acc_en = 1'b1; w.base = BASE_ACC; w.add = ADD_PROD;
                w.mul_en = 1'b1; w.opa = OPA_SINE; w.opb = OPB_GRAV;
                w.shift = SHIFT_SINE;
            end
            PC_GRAV: begin
                w.acc_en = 1'b1; w.base = BASE_ACC; w.add = ADD_PROD;
            end
            PC_DONE: begin
                w.done = 1'b1;
            end
            PC_PD_KP: begin
                w.acc_en = 1'b1; w.base = BASE_INTEG; w.add = ADD_PROD;
                w.mul_en = 1'b1; w.opa = OPA_NEG_MEAS; w.opb = OPB_KP;
            end
            PC_PD_LOAD: begin
                w.wr_integ = 1'b1;
                w.acc_en = 1'b1; w.base = BASE_ZERO; w.add = ADD_PROD;
                w.jump = JMP_ALWAYS; w.target = PC_ADD_INTEG;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// File: sv/pmv_cfg_regs.sv
// Configuration register file of the motor voltage controller.
// Depends on pmv_pkg for the register indexes and the cfg_t bundle.
module pmv_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pmv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmv_pkg::WORD_W-1:0]     cfg_data,
    output pmv_pkg::cfg_t                  cfg
);
    import pmv_pkg::*;

    cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // One register written per beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain         <= '0;
            cfg_reg.integ_gain_dt     <= '0;
            cfg_reg.deriv_gain_per_dt <= '0;
            cfg_reg.mode              <= MODE_RESET;
            cfg_reg.speed_coef        <= '0;
            cfg_reg.friction_coef     <= '0;
            cfg_reg.accel_coef        <= '0;
            cfg_reg.gravity_coef      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_PROP_GAIN:         cfg_reg.prop_gain         <= cfg_data;
                CFG_INTEG_GAIN_DT:     cfg_reg.integ_gain_dt     <= cfg_data;
                CFG_DERIV_GAIN_PER_DT: cfg_reg.deriv_gain_per_dt <= cfg_data;
                CFG_MODE:              cfg_reg.mode              <= cfg_data[MODE_W-1:0];
                CFG_SPEED_COEF:        cfg_reg.speed_coef        <= cfg_data;
                CFG_FRICTION_COEF:     cfg_reg.friction_coef     <= cfg_data;
                CFG_ACCEL_COEF:        cfg_reg.accel_coef        <= cfg_data;
                CFG_GRAVITY_COEF:      cfg_reg.gravity_coef      <= cfg_data;
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

endmodule

// File: sv/pmv_sequencer.sv
// Step counter and control-word fetch for the motor voltage controller.
// Depends on pmv_pkg for the control program and the control bundle.
module pmv_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic               mode_pd,
    output pmv_pkg::seq_ctrl_t ctrl
);
    import pmv_pkg::*;

    logic   busy_reg, busy_next;
    step_e  pc_reg, pc_next;
    logic   out_valid_reg, out_valid_next;
    ucode_t word;
    logic   accept;
    logic   hold;
    logic   step_en;
    logic   jump_taken;

    // Fetch and handshake decode.
    always_comb
    begin
        word    = ucode_rom(pc_reg);
        accept  = in_valid && !busy_reg;
        // The last step waits while an earlier result is still stalled.
        hold    = word.done && out_valid_reg && out_stall;
        step_en = busy_reg && !hold;
        unique case (word.jump)
            JMP_NONE:   jump_taken = 1'b0;
            JMP_ALWAYS: jump_taken = 1'b1;
            JMP_IF_PD:  jump_taken = mode_pd;
            default:    jump_taken = 1'b0;
        endcase
    end

    // Next step, busy flag and output valid.
    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && out_stall;
        priority if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = PC_ISSUE;
        end
        else if (step_en)
        begin
            priority if (word.done)
            begin
                busy_next      = 1'b0;
                out_valid_next = 1'b1;
                pc_next        = PC_ISSUE;
            end
            else if (jump_taken)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = step_e'(pc_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= PC_ISSUE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall     = busy_reg;
    assign out_valid    = out_valid_reg;
    assign ctrl.accept  = accept;
    assign ctrl.step_en = step_en;
    assign ctrl.word    = word;

endmodule

// File: sv/pmv_datapath.sv
// Datapath of the motor voltage controller: operand registers, the shared
// multiplier, the accumulator, loop state and the result registers.
// Depends on pmv_pkg for formats, limits and the control bundle.
module pmv_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pmv_pkg::seq_ctrl_t                ctrl,
    input  pmv_pkg::cfg_t                     cfg,
    input  logic signed [pmv_pkg::WORD_W-1:0] target_speed,
    input  logic signed [pmv_pkg::WORD_W-1:0] measured_speed,
    input  logic signed [pmv_pkg::SINE_W-1:0] load_sine,
    input  logic                              clear,
    output logic signed [pmv_pkg::DRIVE_W-1:0] drive_voltage,
    output logic signed [pmv_pkg::WORD_W-1:0] loop_output,
    output logic                              clamped
);
    import pmv_pkg::*;

    logic signed [WORD_W-1:0]         meas_reg;
    logic signed [ERR_W-1:0]          err_reg;
    logic signed [ERR_W-1:0]          neg_meas_reg;
    logic signed [SINE_W-1:0]         sine_reg;
    logic signed [DIFF_W-1:0]         diff_reg;
    logic signed [ERR_W-1:0]          last_err_reg;
    logic signed [INTEGRAL_WIDTH-1:0] integ_reg;
    logic signed [WORD_W-1:0]         loop_reg;
    logic signed [ACC_W-1:0]          prod_reg;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [DRIVE_W-1:0]        drive_reg;
    logic signed [WORD_W-1:0]         loop_out_reg;
    logic                             clamped_reg;

    logic signed [OPA_W-1:0]          opa;
    logic signed [WORD_W-1:0]         opb;
    logic signed [PROD_W-1:0]         product;
    logic signed [PROD_W-1:0]         shifted;
    logic signed [ACC_W-1:0]          base_val;
    logic signed [ACC_W-1:0]          add_val;
    logic signed [ACC_W-1:0]          fric_ext;
    logic signed [ACC_W-1:0]          volt_lo;
    logic signed [ACC_W-1:0]          volt_clamped;
    logic                             volt_hit;
    logic signed [INTEGRAL_WIDTH-1:0] integ_sat;
    logic signed [WORD_W-1:0]         loop_sat;

    // Input beat: capture the operands and form the error.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            meas_reg     <= measured_speed;
            err_reg      <= ERR_W'(target_speed) - ERR_W'(measured_speed);
            neg_meas_reg <= -ERR_W'(measured_speed);
            sine_reg     <= load_sine;
        end
    end

    // Error difference; settles in the first step and is read in the third.
    always_ff @(posedge clk)
    begin
        diff_reg <= DIFF_W'(err_reg) - DIFF_W'(last_err_reg);
    end

    // Multiplier operand selection.
    always_comb
    begin
        unique case (ctrl.word.opa)
            OPA_ERR:      opa = OPA_W'(err_reg);
            OPA_DIFF:     opa = diff_reg;
            OPA_NEG_MEAS: opa = OPA_W'(neg_meas_reg);
            OPA_MEAS:     opa = OPA_W'(meas_reg);
            OPA_LOOP:     opa = OPA_W'(loop_reg);
            OPA_SINE:     opa = OPA_W'(sine_reg);
            default:      opa = '0;
        endcase
        unique case (ctrl.word.opb)
            OPB_KI:    opb = $signed(cfg.integ_gain_dt);
            OPB_KP:    opb = $signed(cfg.prop_gain);
            OPB_KD:    opb = $signed(cfg.deriv_gain_per_dt);
            OPB_SPEED: opb = $signed(cfg.speed_coef);
            OPB_ACCEL: opb = $signed(cfg.accel_coef);
            OPB_GRAV:  opb = $signed(cfg.gravity_coef);
            default:   opb = '0;
        endcase
    end

    // Shared multiplier; the arithmetic shift rounds toward minus infinity.
    assign product = opa * opb;
    assign shifted = (ctrl.word.shift == SHIFT_SINE) ? (product >>> SINE_FRAC)
                                                     : (product >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (ctrl.step_en && ctrl.word.mul_en)
        begin
            prod_reg <= ACC_W'(shifted);
        end
    end

    // Accumulator operands; friction follows the sign of the measured speed.
    always_comb
    begin
        fric_ext = ACC_W'($signed(cfg.friction_coef));
        unique case (ctrl.word.base)
            BASE_ZERO:  base_val = '0;
            BASE_ACC:   base_val = acc_reg;
            BASE_INTEG: base_val = ACC_W'(integ_reg);
            default:    base_val = '0;
        endcase
        unique case (ctrl.word.add)
            ADD_NONE:  add_val = '0;
            ADD_PROD:  add_val = prod_reg;
            ADD_INTEG: add_val = ACC_W'(integ_reg);
            ADD_FRIC:
            begin
                priority if (meas_reg > 0)
                    add_val = fric_ext;
                else if (meas_reg < 0)
                    add_val = -fric_ext;
                else
                    add_val = '0;
            end
            default:   add_val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step_en && ctrl.word.acc_en)
        begin
            acc_reg <= base_val + add_val;
        end
    end

    // Saturation of the integral and the loop output, clamp of the voltage.
    always_comb
    begin
        priority if (acc_reg > INTEG_MAX)
            integ_sat = INTEG_MAX[INTEGRAL_WIDTH-1:0];
        else if (acc_reg < INTEG_MIN)
            integ_sat = INTEG_MIN[INTEGRAL_WIDTH-1:0];
        else
            integ_sat = acc_reg[INTEGRAL_WIDTH-1:0];

        priority if (acc_reg > LOOP_MAX)
            loop_sat = LOOP_MAX[WORD_W-1:0];
        else if (acc_reg < LOOP_MIN)
            loop_sat = LOOP_MIN[WORD_W-1:0];
        else
            loop_sat = acc_reg[WORD_W-1:0];

        volt_lo = cfg.mode[MODE_NEG_BIT] ? VOLT_LO_NEG : '0;
        priority if (acc_reg > VOLT_HI)
        begin
            volt_clamped = VOLT_HI;
            volt_hit     = 1'b1;
        end
        else if (acc_reg < volt_lo)
        begin
            volt_clamped = volt_lo;
            volt_hit     = 1'b1;
        end
        else
        begin
            volt_clamped = acc_reg;
            volt_hit     = 1'b0;
        end
    end

    // Loop state; clear on the input beat takes effect before the step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            if (ctrl.accept && clear)
            begin
                integ_reg    <= '0;
                last_err_reg <= '0;
            end
            else if (ctrl.step_en && ctrl.word.wr_integ)
            begin
                integ_reg <= integ_sat;
            end
            else if (ctrl.step_en && ctrl.word.wr_loop)
            begin
                last_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step_en && ctrl.word.wr_loop)
        begin
            loop_reg <= loop_sat;
        end
    end

    // Result registers, loaded by the last step.
    always_ff @(posedge clk)
    begin
        if (ctrl.step_en && ctrl.word.done)
        begin
            drive_reg    <= volt_clamped[DRIVE_W-1:0];
            loop_out_reg <= loop_reg;
            clamped_reg  <= volt_hit;
        end
    end

    assign drive_voltage = drive_reg;
    assign loop_output   = loop_out_reg;
    assign clamped       = clamped_reg;

endmodule

// File: sv/pid_motor_voltage_controller.sv
// Top level of the PID motor voltage controller with model feedforward.
// Depends on pmv_pkg, pmv_cfg_regs, pmv_sequencer and pmv_datapath.

// One sample is accepted, then a short control program runs it through a
// single shared 34 x 32 multiplier and one accumulator, issuing at most one
// product per step; the input stalls until the program has run. The PD
// program skips the derivative product; the result lands in an output
// register, so the next sample is taken while it waits, and the last step
// only pauses if the previous result is still stalled. Configuration is
// written through its own port, which is always ready; write it only while
// no sample is in flight.
// There is no clearing pass after reset.
module pid_motor_voltage_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [pmv_pkg::WORD_W-1:0]  target_speed,
    input  logic signed [pmv_pkg::WORD_W-1:0]  measured_speed,
    input  logic signed [pmv_pkg::SINE_W-1:0]  load_sine,
    input  logic                               clear,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pmv_pkg::DRIVE_W-1:0] drive_voltage,
    output logic signed [pmv_pkg::WORD_W-1:0]  loop_output,
    output logic                               clamped,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pmv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmv_pkg::WORD_W-1:0]         cfg_data
);
    import pmv_pkg::*;

    cfg_t      cfg;
    seq_ctrl_t ctrl;

    pmv_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pmv_sequencer u_sequencer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mode_pd   (cfg.mode[MODE_PD_BIT]),
        .ctrl      (ctrl)
    );

    pmv_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg            (cfg),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .load_sine      (load_sine),
        .clear          (clear),
        .drive_voltage  (drive_voltage),
        .loop_output    (loop_output),
        .clamped        (clamped)
    );

    // An accepted beat starts the program, so the input side stalls next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an accepted beat");

    // A result appears only after the last program step has run.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl.step_en && ctrl.word.done))
        else $error("output valid without a finished program");

    // The last step never overwrites a result that is still stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step_en && ctrl.word.done) |-> !(out_valid && out_stall))
        else $error("result register overwritten while stalled");

endmodule
